// ----- rtl/core/pmh_pkg.sv -----
// shared types, constants and tables for the polyline midpoint and heading block
package pmh_pkg;

   // defaults for the top level parameters
   localparam int MAX_POINTS_DEF   = 1024;
   localparam int CORDIC_STEPS_DEF = 16;

   // fixed widths
   localparam int COORD_W = 32;
   localparam int SEG_W   = 33;   // floor sqrt of dx^2+dy^2 stays below 2^33
   localparam int DEN_W   = 34;   // doubled segment length
   localparam int LEN_W   = 48;   // running total of segment lengths
   localparam int SQ_W    = 66;   // sum of two squares
   localparam int FRAC_W  = 30;   // interpolation fraction bits
   localparam int DIFF_W  = 33;   // coordinate difference
   localparam int CRD_W   = 36;   // cordic x and y
   localparam int ANG_W   = 21;   // cordic angle, Q16 radians
   localparam int HEAD_W  = 16;

   localparam logic [15:0]         MIN_LEN_RESET = 16'd3;
   localparam logic [LEN_W-1:0]    LEN_MAX       = {LEN_W{1'b1}};
   localparam logic signed [ANG_W-1:0] PI_Q16    = 21'sd205887;
   localparam logic signed [HEAD_W-1:0] HEAD_LIMIT = 16'sd25736;

   // outcome codes
   localparam logic [1:0] OUT_FOUND     = 2'd0;
   localparam logic [1:0] OUT_SHORT     = 2'd1;
   localparam logic [1:0] OUT_EMPTY     = 2'd2;
   localparam logic [1:0] OUT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      starts_line;
      logic                      point_present;
      logic                      set_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] middle_x;
      logic signed [COORD_W-1:0] middle_y;
      logic signed [COORD_W-1:0] middle_z;
      logic signed [HEAD_W-1:0]  heading;
      logic [1:0]                outcome;
      logic                      overflowed;
   } rsp_type;

   // one stored point with its incoming segment length
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      mark;
      logic [SEG_W-1:0]          len;
   } entry_type;

   // command into the shared root / divide unit
   typedef struct packed {
      logic start;
      logic is_div;
   } root_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_ROOT_WAIT,
      ST_CHECK_END,
      ST_FIRST,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_DIV,
      ST_DIV_WAIT,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_CORDIC,
      ST_CORDIC_WAIT,
      ST_EMIT
   } state_type;

   // atan(2^-i) in Q16 radians, zero past the table
   function automatic logic [ANG_W-1:0] atan_q16(input logic [5:0] idx);
      logic [ANG_W-1:0] val;
      unique case (idx)
         6'd0:    val = 21'd51472;
         6'd1:    val = 21'd30385;
         6'd2:    val = 21'd16055;
         6'd3:    val = 21'd8150;
         6'd4:    val = 21'd4091;
         6'd5:    val = 21'd2047;
         6'd6:    val = 21'd1024;
         6'd7:    val = 21'd512;
         6'd8:    val = 21'd256;
         6'd9:    val = 21'd128;
         6'd10:   val = 21'd64;
         6'd11:   val = 21'd32;
         6'd12:   val = 21'd16;
         6'd13:   val = 21'd8;
         6'd14:   val = 21'd4;
         6'd15:   val = 21'd2;
         6'd16:   val = 21'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/pmh_store.sv -----
// point memory: one write port, one registered read port
module pmh_store #(
   parameter int DEPTH = pmh_pkg::MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  pmh_pkg::entry_type       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output pmh_pkg::entry_type       rd_data
);

   pmh_pkg::entry_type mem_ff [DEPTH];
   pmh_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pmh_root_div.sv -----
// shared shift / compare / subtract unit: integer square root or fraction divide
module pmh_root_div (
   input  logic                        clock,
   input  logic                        reset,
   input  pmh_pkg::root_cmd_type       cmd,
   input  logic [pmh_pkg::SQ_W-1:0]    radicand,
   input  logic [pmh_pkg::DEN_W:0]     numer,
   input  logic [pmh_pkg::DEN_W-1:0]   den,
   output logic                        done,
   output logic [pmh_pkg::SEG_W-1:0]   result
);

   localparam int REM_W = 38;

   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [pmh_pkg::SQ_W-1:0]    rad_ff, rad_in;
   logic [pmh_pkg::SEG_W-1:0]   res_ff, res_in;
   logic [pmh_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic                        div_ff, div_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            shifted;
   logic [REM_W-1:0]            trial;
   logic                        fits;

   // one digit step
   always_comb begin
      shifted = div_ff ? {rem_ff[REM_W-2:0], 1'b0}
                       : {rem_ff[REM_W-3:0], rad_ff[pmh_pkg::SQ_W-1 -: 2]};
      trial   = div_ff ? REM_W'(den_ff) : REM_W'({res_ff, 2'b01});
      fits    = (shifted >= trial);
   end

   // sequencing of the steps
   always_comb begin
      rem_in  = rem_ff;
      rad_in  = rad_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         div_in = cmd.is_div;
         rad_in = radicand;
         den_in = den;
         res_in = '0;
         rem_in = cmd.is_div ? REM_W'(numer) : '0;
         cnt_in = cmd.is_div ? 6'(pmh_pkg::FRAC_W) : 6'(pmh_pkg::SEG_W);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? (shifted - trial) : shifted;
         res_in  = {res_ff[pmh_pkg::SEG_W-2:0], fits};
         rad_in  = {rad_ff[pmh_pkg::SQ_W-3:0], 2'b00};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      rad_ff <= rad_in;
      res_ff <= res_in;
      den_ff <= den_in;
      div_ff <= div_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ----- rtl/core/pmh_cordic.sv -----
// iterative cordic vectoring for the segment heading
module pmh_cordic #(
   parameter int CORDIC_STEPS = pmh_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pmh_pkg::DIFF_W-1:0]   dx,
   input  logic signed [pmh_pkg::DIFF_W-1:0]   dy,
   output logic                                done,
   output logic signed [pmh_pkg::HEAD_W-1:0]   heading
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   logic signed [pmh_pkg::CRD_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [pmh_pkg::ANG_W-1:0] z_ff, z_in, ang;
   logic [STEP_W-1:0]                step_ff, step_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic signed [pmh_pkg::ANG_W:0]   zr;
   logic signed [pmh_pkg::ANG_W-3:0] zs;

   // one rotation step
   always_comb begin
      xs  = x_ff >>> step_ff;
      ys  = y_ff >>> step_ff;
      ang = $signed(pmh_pkg::atan_q16(6'(step_ff)));
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
         if (dx < 0) begin
            x_in = -pmh_pkg::CRD_W'(dx);
            y_in = -pmh_pkg::CRD_W'(dy);
            z_in = (dy >= 0) ? pmh_pkg::PI_Q16 : -pmh_pkg::PI_Q16;
         end else begin
            x_in = pmh_pkg::CRD_W'(dx);
            y_in = pmh_pkg::CRD_W'(dy);
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   // round to Q3.13 and clamp
   always_comb begin
      zr = (pmh_pkg::ANG_W+1)'(z_ff) + 22'sd4;
      zs = zr[pmh_pkg::ANG_W:3];
      if (zs > (pmh_pkg::ANG_W-2)'(pmh_pkg::HEAD_LIMIT)) begin
         heading = pmh_pkg::HEAD_LIMIT;
      end else if (zs < -(pmh_pkg::ANG_W-2)'(pmh_pkg::HEAD_LIMIT)) begin
         heading = -pmh_pkg::HEAD_LIMIT;
      end else begin
         heading = zs[pmh_pkg::HEAD_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// ----- rtl/core/polyline_midpoint_and_heading_top.sv -----
// top level: point loading, set-end walk, interpolation and result register
//
//   channel  ports                             direction  beat
//   req      req_valid req_stall req_data      in         one point or set close
//   rsp      rsp_valid rsp_stall rsp_data      out        one middle point result
//   csr      csr_valid csr_ready csr_data      in         min_total_length write
//
// A point that adds a segment runs two squaring passes on the shared multiplier and
// 33 steps of the bit-serial root unit before the next beat is taken.
// A set close walks the stored points through the point memory read port, with a
// read state and a check state per point, then 30 divide steps, a multiply and an
// add state per coordinate, and CORDIC_STEPS rotation steps for the heading.
// Reset is synchronous; the point memory needs no clearing pass.
// req is taken only when the sequencer is idle; a waiting result holds in
// its register while the next points are loaded.
module polyline_midpoint_and_heading_top #(
   parameter int MAX_POINTS   = pmh_pkg::MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = pmh_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pmh_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pmh_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W = $clog2(MAX_POINTS);

   pmh_pkg::state_type state_ff, state_in;

   pmh_pkg::req_type   item_ff, item_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [pmh_pkg::LEN_W-1:0] total_ff, total_in, left_ff, left_in;
   logic               ovf_ff, ovf_in;
   logic [15:0]        min_len_ff;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic signed [pmh_pkg::COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [pmh_pkg::DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [pmh_pkg::DIFF_W-1:0]         ax, ay;
   logic [pmh_pkg::SQ_W-1:0]           sq_ff, sq_in;
   pmh_pkg::entry_type pe_ff, pe_in, cur_ff, cur_in;
   logic [pmh_pkg::FRAC_W-1:0]         t_ff, t_in;
   logic [1:0]         lidx_ff, lidx_in;
   logic [pmh_pkg::SQ_W-1:0]           prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic signed [pmh_pkg::COORD_W-1:0] a_ff, a_in;
   logic signed [pmh_pkg::COORD_W-1:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic signed [pmh_pkg::HEAD_W-1:0]  hd_ff, hd_in;
   logic [1:0]         oc_ff, oc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pmh_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               accept, emit_ok;
   logic [pmh_pkg::DIFF_W-1:0] mul_a, mul_b;
   logic [pmh_pkg::SQ_W-1:0]   mul_p;
   logic signed [pmh_pkg::COORD_W-1:0] ca, cb;
   logic signed [pmh_pkg::DIFF_W-1:0]  cd;
   logic [pmh_pkg::SQ_W-1:0]   off_full;
   logic [pmh_pkg::DIFF_W-1:0] off;
   logic signed [pmh_pkg::COORD_W-1:0] lerp_val;
   logic [pmh_pkg::DEN_W-1:0]  den_chk;
   logic [pmh_pkg::LEN_W:0]    total_sum;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   pmh_pkg::entry_type wr_data, rd_data;
   pmh_pkg::root_cmd_type root_cmd;
   logic               root_done;
   logic [pmh_pkg::SEG_W-1:0] root_res;
   logic               cor_start, cor_done;
   logic signed [pmh_pkg::DIFF_W-1:0] cor_dx, cor_dy;
   logic signed [pmh_pkg::HEAD_W-1:0] cor_head;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != pmh_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign emit_ok   = !rsp_valid_ff || !rsp_stall;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= pmh_pkg::MIN_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         min_len_ff <= csr_data;
      end
   end

   // shared multiplier: squares while loading, offsets while interpolating
   always_comb begin
      ax = dx_ff[pmh_pkg::DIFF_W-1] ? pmh_pkg::DIFF_W'(-dx_ff) : pmh_pkg::DIFF_W'(dx_ff);
      ay = dy_ff[pmh_pkg::DIFF_W-1] ? pmh_pkg::DIFF_W'(-dy_ff) : pmh_pkg::DIFF_W'(dy_ff);
      unique case (lidx_ff)
         2'd0:    begin ca = pe_ff.x; cb = cur_ff.x; end
         2'd1:    begin ca = pe_ff.y; cb = cur_ff.y; end
         default: begin ca = pe_ff.z; cb = cur_ff.z; end
      endcase
      cd = pmh_pkg::DIFF_W'(cb) - pmh_pkg::DIFF_W'(ca);
      unique case (state_ff)
         pmh_pkg::ST_SQ_X: begin
            mul_a = ax;
            mul_b = ax;
         end
         pmh_pkg::ST_SQ_Y: begin
            mul_a = ay;
            mul_b = ay;
         end
         default: begin
            mul_a = cd[pmh_pkg::DIFF_W-1] ? pmh_pkg::DIFF_W'(-cd) : pmh_pkg::DIFF_W'(cd);
            mul_b = pmh_pkg::DIFF_W'(t_ff);
         end
      endcase
      mul_p = pmh_pkg::SQ_W'(mul_a) * pmh_pkg::SQ_W'(mul_b);
   end

   // rounding add after the registered product
   always_comb begin
      off_full = prod_ff + (pmh_pkg::SQ_W'(1) << (pmh_pkg::FRAC_W - 1));
      off      = off_full[pmh_pkg::FRAC_W +: pmh_pkg::DIFF_W];
      lerp_val = neg_ff ? (a_ff - off[pmh_pkg::COORD_W-1:0])
                        : (a_ff + off[pmh_pkg::COORD_W-1:0]);
      den_chk   = {rd_data.len, 1'b0};
      total_sum = {1'b0, total_ff} + (pmh_pkg::LEN_W+1)'(root_res);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmh_pkg::ST_IDLE: begin
            if (accept) state_in = pmh_pkg::ST_LOAD;
         end
         pmh_pkg::ST_LOAD: begin
            if (!item_ff.point_present || count_ff >= CNT_W'(MAX_POINTS) ||
                count_ff == '0 || item_ff.starts_line) begin
               state_in = pmh_pkg::ST_CHECK_END;
            end else begin
               state_in = pmh_pkg::ST_SQ_X;
            end
         end
         pmh_pkg::ST_SQ_X:      state_in = pmh_pkg::ST_SQ_Y;
         pmh_pkg::ST_SQ_Y:      state_in = pmh_pkg::ST_ROOT;
         pmh_pkg::ST_ROOT:      state_in = pmh_pkg::ST_ROOT_WAIT;
         pmh_pkg::ST_ROOT_WAIT: begin
            if (root_done) state_in = pmh_pkg::ST_CHECK_END;
         end
         pmh_pkg::ST_CHECK_END: begin
            if (!item_ff.set_end) begin
               state_in = pmh_pkg::ST_IDLE;
            end else if (count_ff == '0) begin
               state_in = pmh_pkg::ST_EMIT;
            end else begin
               state_in = pmh_pkg::ST_FIRST;
            end
         end
         pmh_pkg::ST_FIRST: begin
            if (total_ff < pmh_pkg::LEN_W'(min_len_ff)) begin
               state_in = pmh_pkg::ST_EMIT;
            end else begin
               state_in = pmh_pkg::ST_WALK_RD;
            end
         end
         pmh_pkg::ST_WALK_RD: begin
            if (walk_ff >= count_ff) begin
               state_in = pmh_pkg::ST_EMIT;
            end else begin
               state_in = pmh_pkg::ST_WALK_CHK;
            end
         end
         pmh_pkg::ST_WALK_CHK: begin
            if (!rd_data.mark && pmh_pkg::LEN_W'(den_chk) > left_ff) begin
               state_in = pmh_pkg::ST_DIV;
            end else begin
               state_in = pmh_pkg::ST_WALK_RD;
            end
         end
         pmh_pkg::ST_DIV:      state_in = pmh_pkg::ST_DIV_WAIT;
         pmh_pkg::ST_DIV_WAIT: begin
            if (root_done) state_in = pmh_pkg::ST_LERP_MUL;
         end
         pmh_pkg::ST_LERP_MUL: state_in = pmh_pkg::ST_LERP_ADD;
         pmh_pkg::ST_LERP_ADD: begin
            state_in = (lidx_ff == 2'd2) ? pmh_pkg::ST_CORDIC : pmh_pkg::ST_LERP_MUL;
         end
         pmh_pkg::ST_CORDIC:      state_in = pmh_pkg::ST_CORDIC_WAIT;
         pmh_pkg::ST_CORDIC_WAIT: begin
            if (cor_done) state_in = pmh_pkg::ST_EMIT;
         end
         pmh_pkg::ST_EMIT: begin
            if (emit_ok) state_in = pmh_pkg::ST_IDLE;
         end
         default: state_in = pmh_pkg::ST_IDLE;
      endcase
   end

   // datapath and unit controls per state
   always_comb begin
      item_in   = item_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      left_in   = left_ff;
      ovf_in    = ovf_ff;
      walk_in   = walk_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sq_in     = sq_ff;
      pe_in     = pe_ff;
      cur_in    = cur_ff;
      t_in      = t_ff;
      lidx_in   = lidx_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      a_in      = a_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      mz_in     = mz_ff;
      hd_in     = hd_ff;
      oc_in     = oc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en     = 1'b0;
      wr_addr   = count_ff[ADDR_W-1:0];
      wr_data   = '{x: item_ff.point_x, y: item_ff.point_y, z: item_ff.point_z,
                    mark: 1'b1, len: '0};
      rd_en     = 1'b0;
      rd_addr   = walk_ff[ADDR_W-1:0];
      root_cmd  = '{start: 1'b0, is_div: 1'b0};
      cor_start = 1'b0;
      cor_dx    = pmh_pkg::DIFF_W'(cur_ff.x) - pmh_pkg::DIFF_W'(pe_ff.x);
      cor_dy    = pmh_pkg::DIFF_W'(cur_ff.y) - pmh_pkg::DIFF_W'(pe_ff.y);
      unique case (state_ff)
         pmh_pkg::ST_IDLE: begin
            if (accept) item_in = req_data;
         end
         pmh_pkg::ST_LOAD: begin
            dx_in = pmh_pkg::DIFF_W'(item_ff.point_x) - pmh_pkg::DIFF_W'(prev_x_ff);
            dy_in = pmh_pkg::DIFF_W'(item_ff.point_y) - pmh_pkg::DIFF_W'(prev_y_ff);
            if (item_ff.point_present) begin
               if (count_ff >= CNT_W'(MAX_POINTS)) begin
                  ovf_in = 1'b1;
               end else if (count_ff == '0 || item_ff.starts_line) begin
                  wr_en     = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  prev_x_in = item_ff.point_x;
                  prev_y_in = item_ff.point_y;
               end
            end
         end
         pmh_pkg::ST_SQ_X: sq_in = mul_p;
         pmh_pkg::ST_SQ_Y: sq_in = sq_ff + mul_p;
         pmh_pkg::ST_ROOT: root_cmd = '{start: 1'b1, is_div: 1'b0};
         pmh_pkg::ST_ROOT_WAIT: begin
            if (root_done) begin
               wr_en        = 1'b1;
               wr_data.mark = 1'b0;
               wr_data.len  = root_res;
               count_in     = count_ff + CNT_W'(1);
               total_in     = total_sum[pmh_pkg::LEN_W] ? pmh_pkg::LEN_MAX
                                                        : total_sum[pmh_pkg::LEN_W-1:0];
               prev_x_in    = item_ff.point_x;
               prev_y_in    = item_ff.point_y;
            end
         end
         pmh_pkg::ST_CHECK_END: begin
            rd_en   = 1'b1;
            rd_addr = '0;
            walk_in = CNT_W'(1);
            left_in = total_ff;
            mx_in   = '0;
            my_in   = '0;
            mz_in   = '0;
            hd_in   = '0;
            oc_in   = pmh_pkg::OUT_EMPTY;
         end
         pmh_pkg::ST_FIRST: begin
            pe_in    = rd_data;
            mx_in    = rd_data.x;
            my_in    = rd_data.y;
            mz_in    = rd_data.z;
            oc_in    = (total_ff < pmh_pkg::LEN_W'(min_len_ff)) ? pmh_pkg::OUT_SHORT
                                                                : pmh_pkg::OUT_NOT_FOUND;
         end
         pmh_pkg::ST_WALK_RD: begin
            rd_en = (walk_ff < count_ff);
         end
         pmh_pkg::ST_WALK_CHK: begin
            if (!rd_data.mark && pmh_pkg::LEN_W'(den_chk) > left_ff) begin
               cur_in = rd_data;
            end else begin
               if (!rd_data.mark) left_in = left_ff - pmh_pkg::LEN_W'(den_chk);
               pe_in   = rd_data;
               walk_in = walk_ff + CNT_W'(1);
            end
         end
         pmh_pkg::ST_DIV: begin
            root_cmd = '{start: 1'b1, is_div: 1'b1};
            lidx_in  = 2'd0;
         end
         pmh_pkg::ST_DIV_WAIT: begin
            if (root_done) t_in = root_res[pmh_pkg::FRAC_W-1:0];
         end
         pmh_pkg::ST_LERP_MUL: begin
            prod_in = mul_p;
            neg_in  = cd[pmh_pkg::DIFF_W-1];
            a_in    = ca;
         end
         pmh_pkg::ST_LERP_ADD: begin
            unique case (lidx_ff)
               2'd0:    mx_in = lerp_val;
               2'd1:    my_in = lerp_val;
               default: mz_in = lerp_val;
            endcase
            lidx_in = lidx_ff + 2'd1;
         end
         pmh_pkg::ST_CORDIC: cor_start = 1'b1;
         pmh_pkg::ST_CORDIC_WAIT: begin
            if (cor_done) begin
               hd_in = cor_head;
               oc_in = pmh_pkg::OUT_FOUND;
            end
         end
         pmh_pkg::ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{middle_x: mx_ff, middle_y: my_ff, middle_z: mz_ff,
                                heading: hd_ff, outcome: oc_ff, overflowed: ovf_ff};
               count_in     = '0;
               total_in     = '0;
               ovf_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmh_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      left_ff     <= left_in;
      walk_ff     <= walk_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sq_ff       <= sq_in;
      pe_ff       <= pe_in;
      cur_ff      <= cur_in;
      t_ff        <= t_in;
      lidx_ff     <= lidx_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      a_ff        <= a_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      mz_ff       <= mz_in;
      hd_ff       <= hd_in;
      oc_ff       <= oc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pmh_store #(
      .DEPTH(MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pmh_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (root_cmd),
      .radicand (sq_ff),
      .numer    (left_ff[pmh_pkg::DEN_W:0]),
      .den      ({cur_ff.len, 1'b0}),
      .done     (root_done),
      .result   (root_res)
   );

   pmh_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .dx      (cor_dx),
      .dy      (cor_dy),
      .done    (cor_done),
      .heading (cor_head)
   );

endmodule

// ----- rtl/core/pmh_checker.sv -----
// port-level checks for the polyline midpoint block, bound to the top level
module pmh_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pmh_pkg::rsp_type rsp_data
);

   // a held result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a taken request beat keeps the block busy the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready right after a request beat");

   // heading within its clamp
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.heading <= pmh_pkg::HEAD_LIMIT &&
                     rsp_data.heading >= -pmh_pkg::HEAD_LIMIT))
      else $error("heading out of range");

   // heading only for a found middle
   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome != pmh_pkg::OUT_FOUND |-> rsp_data.heading == '0)
      else $error("heading set without a found segment");

endmodule

bind polyline_midpoint_and_heading_top pmh_checker u_pmh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- verif/polyline_midpoint_and_heading_top_tb.sv -----
// testbench for the polyline midpoint and heading block: directed and random point sets
module polyline_midpoint_and_heading_top_tb;

   localparam int CAP   = 1024;
   localparam int STEPS = 16;
   localparam longint ATAN_Q16 [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2, 1};

   typedef struct {
      pmh_pkg::req_type beat;
      bit               drain_first;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   pmh_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   pmh_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [15:0] csr_data = '0;

   pending_type      pending_q[$];
   pmh_pkg::rsp_type midpoint_q[$];
   int          mismatches = 0;
   bit          req_taken = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_cycles = 0;

   // predictor state
   longint      pt_x [CAP];
   longint      pt_y [CAP];
   longint      pt_z [CAP];
   bit          pt_mark [CAP];
   int          pt_count = 0;
   logic [47:0] len_sum = '0;
   bit          dropped = 1'b0;
   logic [15:0] min_len = pmh_pkg::MIN_LEN_RESET;

   polyline_midpoint_and_heading_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact floor sqrt of dx^2 + dy^2
   function automatic logic [32:0] xy_len(longint dx, longint dy);
      logic [67:0] ax, ay, s, cand, res;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      s = ax * ax + ay * ay;
      res = '0;
      for (int b = 32; b >= 0; b--) begin
         cand = res | (68'd1 << b);
         if (cand * cand <= s) res = cand;
      end
      return res[32:0];
   endfunction

   function automatic longint lerp_coord(longint a, longint b, logic [63:0] t);
      longint d;
      logic [63:0] mag, off;
      d = b - a;
      mag = (d < 0) ? -d : d;
      off = (mag * t + (64'd1 << 29)) >> 30;
      return (d < 0) ? a - longint'(off) : a + longint'(off);
   endfunction

   function automatic logic signed [15:0] seg_heading(longint dx, longint dy);
      longint x, y, z, xs, ys, h;
      x = dx;
      y = dy;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? 205887 : -205887;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z += (i < 17) ? ATAN_Q16[i] : 0;
         end else begin
            x = x - ys;
            y = y + xs;
            z -= (i < 17) ? ATAN_Q16[i] : 0;
         end
      end
      h = (z + 4) >>> 3;
      if (h > 25736) h = 25736;
      if (h < -25736) h = -25736;
      return h[15:0];
   endfunction

   // take one accepted beat, push the midpoint result when it closes a set
   task automatic take_point(pmh_pkg::req_type r);
      pmh_pkg::rsp_type m;
      logic [63:0] left, den, rem, t;
      int          n;
      longint      s;
      if (r.point_present) begin
         if (pt_count < CAP) begin
            n = pt_count;
            pt_x[n] = r.point_x;
            pt_y[n] = r.point_y;
            pt_z[n] = r.point_z;
            pt_mark[n] = (n == 0) || r.starts_line;
            if (!pt_mark[n]) begin
               s = xy_len(pt_x[n] - pt_x[n-1], pt_y[n] - pt_y[n-1]);
               len_sum = ({1'b0, len_sum} + s > {1'b0, pmh_pkg::LEN_MAX}) ?
                         pmh_pkg::LEN_MAX : 48'(len_sum + s);
            end
            pt_count = n + 1;
         end else begin
            dropped = 1'b1;
         end
      end
      if (!r.set_end) return;
      m = '0;
      if (pt_count == 0) begin
         m.outcome = pmh_pkg::OUT_EMPTY;
      end else begin
         m.middle_x = 32'(pt_x[0]);
         m.middle_y = 32'(pt_y[0]);
         m.middle_z = 32'(pt_z[0]);
         if (len_sum < min_len) begin
            m.outcome = pmh_pkg::OUT_SHORT;
         end else begin
            m.outcome = pmh_pkg::OUT_NOT_FOUND;
            left = len_sum;
            for (int i = 1; i < pt_count; i++) begin
               if (pt_mark[i]) continue;
               den = 2 * xy_len(pt_x[i] - pt_x[i-1], pt_y[i] - pt_y[i-1]);
               if (den <= left) begin
                  left -= den;
                  continue;
               end
               rem = left;
               t = 0;
               for (int k = 0; k < 30; k++) begin
                  rem = rem << 1;
                  t = t << 1;
                  if (rem >= den) begin
                     rem -= den;
                     t[0] = 1'b1;
                  end
               end
               m.middle_x = 32'(lerp_coord(pt_x[i-1], pt_x[i], t));
               m.middle_y = 32'(lerp_coord(pt_y[i-1], pt_y[i], t));
               m.middle_z = 32'(lerp_coord(pt_z[i-1], pt_z[i], t));
               m.heading = seg_heading(pt_x[i] - pt_x[i-1], pt_y[i] - pt_y[i-1]);
               m.outcome = pmh_pkg::OUT_FOUND;
               break;
            end
         end
      end
      m.overflowed = dropped;
      midpoint_q.push_back(m);
      pt_count = 0;
      len_sum = '0;
      dropped = 1'b0;
   endtask

   // accept side: predict on req beats, check rsp beats
   always @(posedge clock) begin
      pmh_pkg::rsp_type want;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) take_point(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (midpoint_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = midpoint_q.pop_front();
            if (rsp_data.middle_x !== want.middle_x || rsp_data.middle_y !== want.middle_y ||
                rsp_data.middle_z !== want.middle_z || rsp_data.heading !== want.heading ||
                rsp_data.outcome !== want.outcome || rsp_data.overflowed !== want.overflowed)
            begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   // driver: bursts and gaps from the pending queue
   always @(negedge clock) begin
      bit               nv;
      pmh_pkg::req_type nd;
      if (!reset) begin
         nv = req_valid;
         nd = req_data;
         if (!req_valid || req_taken) begin
            nv = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && midpoint_q.size() > 0)) begin
               nd = pending_q.pop_front().beat;
               nv = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end
            end
         end
         req_valid <= nv;
         req_data <= nd;
         // receiver stall pattern changes every so often
         if (stall_cycles == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cycles = $urandom_range(50, 400);
         end
         stall_cycles--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= ($urandom_range(0, 9) != 0);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic queue_beat(longint x, longint y, longint z, bit sl, bit pres, bit last,
                             bit drain = 1'b0);
      pending_type p;
      p.beat.point_x = 32'(x);
      p.beat.point_y = 32'(y);
      p.beat.point_z = 32'(z);
      p.beat.starts_line = sl;
      p.beat.point_present = pres;
      p.beat.set_end = last;
      p.drain_first = drain;
      pending_q.push_back(p);
   endtask

   function automatic longint rand_coord(int style);
      case (style)
         0: return longint'($signed($urandom()));
         1: return longint'($signed($urandom_range(0, 4000))) - 2000;
         default: return longint'($signed($urandom_range(0, 200000))) - 100000;
      endcase
   endfunction

   // one random point set, mostly well formed
   task automatic queue_set(int n);
      int style;
      bit repeat_pt;
      longint x, y, z;
      style = $urandom_range(0, 2);
      repeat_pt = ($urandom_range(0, 9) == 0);
      x = rand_coord(style);
      y = rand_coord(style);
      z = rand_coord(0);
      for (int i = 0; i < n; i++) begin
         if (!repeat_pt) begin
            x = rand_coord(style);
            y = rand_coord(style);
            z = rand_coord(0);
         end
         if ($urandom_range(0, 15) == 0) queue_beat(rand_coord(0), rand_coord(0), 0, 1, 0, 0);
         queue_beat(x, y, z, $urandom_range(0, 4) == 0, 1, i == n - 1);
      end
      if (n == 0 || $urandom_range(0, 9) == 0) queue_beat(0, 0, 0, 0, 0, 1);
   endtask

   task automatic write_min_len(logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      min_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_all();
      while (pending_q.size() > 0 || req_valid || midpoint_q.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty set, lone point, extremes, ignored beat, two lines
      queue_beat(0, 0, 0, 0, 0, 1);
      queue_beat(5, 6, 7, 0, 1, 1);
      queue_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 1, 0);
      queue_beat(-32'sh80000000, -32'sh80000000, -32'sh80000000, 0, 1, 1);
      queue_beat(-32'sh80000000, 32'sh7fffffff, 0, 0, 1, 0);
      queue_beat(32'sh7fffffff, -32'sh80000000, -1, 0, 1, 1);
      queue_beat(100, 200, 300, 1, 1, 0);
      queue_beat(-1, -1, -1, 1, 0, 0);
      queue_beat(100, 201, 300, 0, 1, 0);
      queue_beat(1000, 1000, 0, 1, 1, 0);
      queue_beat(0, 0, 1000, 0, 1, 0);
      queue_beat(0, 0, 0, 0, 0, 1);
      queue_beat(0, 0, 0, 0, 1, 0);
      queue_beat(-4000, 0, 0, 0, 1, 0);
      queue_beat(-4000, 3000, 0, 0, 1, 1, 1'b1);
      queue_beat(10, 10, 10, 0, 1, 0);
      queue_beat(10, 10, 10, 0, 1, 1);
      for (int i = 0; i < 15; i++) queue_set($urandom_range(0, 6));
      drain_all();

      // zero threshold: zero-length sets give not found
      write_min_len(16'd0);
      queue_beat(7, 7, 7, 0, 1, 0);
      queue_beat(7, 7, 9, 0, 1, 1);
      queue_beat(1, 2, 3, 0, 1, 0);
      queue_beat(4, 5, 6, 1, 1, 1);
      queue_beat(3, 3, 3, 0, 1, 1);
      for (int i = 0; i < 15; i++) queue_set($urandom_range(0, 6));
      drain_all();

      // top threshold
      write_min_len(16'hffff);
      for (int i = 0; i < 15; i++) queue_set($urandom_range(1, 6));
      drain_all();

      // capacity overflow with small steps
      write_min_len(16'($urandom()));
      for (int i = 0; i < CAP + 4; i++)
         queue_beat(i * 3, i * 2, i, ($urandom_range(0, 30) == 0), 1, i == CAP + 3);
      for (int i = 0; i < 10; i++) queue_set($urandom_range(0, 8));
      drain_all();

      write_min_len(pmh_pkg::MIN_LEN_RESET);
      for (int i = 0; i < 10; i++) queue_set($urandom_range(0, 8));
      drain_all();

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
